/* rtl/kes_pkg.sv */
// Types, constants and the CORDIC arctangent table shared by the Kepler solver modules.
package kes_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 34;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] GAIN_INV    = 34'sd652032874;
  localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;

  // Register indexes on the configuration port.
  localparam logic REG_MAX_ITER = 1'b0;
  localparam logic REG_TOL      = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED0, ST_RED1, ST_RED2, ST_CORDIC,
    ST_MUL_S, ST_MUL_C, ST_PREP, ST_DIV, ST_UPDATE, ST_FIN
  } kes_state_t;

  typedef struct packed {
    logic       load;
    logic       red0;
    logic       red1;
    logic       red2;
    logic       cordic;
    logic [4:0] cidx;
    logic       mul_s;
    logic       mul_c;
    logic       prep;
    logic       div;
    logic       update;
    logic       out_load;
  } kes_cmd_t;

  typedef struct packed {
    logic early;
    logic den_zero;
  } kes_sts_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    unique case (i)
      5'd0:  r = 36'sd843314856;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043836;
      5'd3:  r = 36'sd133525158;
      5'd4:  r = 36'sd67021686;
      5'd5:  r = 36'sd33543515;
      5'd6:  r = 36'sd16775850;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194282;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048575;
      5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;
      5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;
      5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;
      5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;
      5'd19: r = 36'sd2047;
      5'd20: r = 36'sd1023;
      5'd21: r = 36'sd511;
      5'd22: r = 36'sd255;
      5'd23: r = 36'sd127;
      5'd24: r = 36'sd63;
      5'd25: r = 36'sd31;
      5'd26: r = 36'sd15;
      5'd27: r = 36'sd7;
      5'd28: r = 36'sd3;
      5'd29: r = 36'sd1;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/kes_dp.sv */
// Datapath of the Kepler solver: angle folding, CORDIC, multiplier, divider and update.
module kes_dp
  import kes_pkg::*;
(
  input  logic        clk,
  input  kes_cmd_t    cmd,
  output kes_sts_t    sts,
  input  logic [31:0] mean_anomaly,
  input  logic [30:0] eccentricity,
  input  logic [15:0] tolerance,
  output logic [31:0] e_solved
);

  logic signed [31:0] m_r, e_r;
  logic        [30:0] ecc_r;
  logic signed [35:0] a_r;
  logic               neg_r;
  logic signed [33:0] x_r, y_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] es_r;
  logic signed [34:0] num_r;
  logic        [31:0] den_r;
  logic               ovf_r;
  logic        [31:0] rem_r;
  logic        [33:0] qd_r;
  logic        [31:0] out_r;

  logic signed [35:0] a4, a_fold;
  logic signed [33:0] sh_x, sh_y;
  logic signed [33:0] trig;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] es_full, ec_full;
  logic signed [34:0] ec, den_full, num;
  logic        [33:0] absn;
  logic        [32:0] trial;
  logic               qbit;
  logic signed [36:0] diff;
  logic signed [31:0] e_new;
  logic               early;

  function automatic logic signed [35:0] fold(input logic signed [35:0] v);
    logic signed [35:0] r;
    if (v > PI_Q30) r = v - TWO_PI_Q30;
    else if (v < -PI_Q30) r = v + TWO_PI_Q30;
    else r = v;
    return r;
  endfunction

  assign a4     = {{2{e_r[31]}}, e_r, 2'b00};
  assign a_fold = fold(cmd.red0 ? a4 : a_r);
  assign sh_x   = x_r >>> cmd.cidx;
  assign sh_y   = y_r >>> cmd.cidx;

  // Sine in the mul_s step, cosine in the mul_c step; one shared multiplier.
  assign trig  = cmd.mul_s ? (neg_r ? -y_r : y_r) : (neg_r ? -x_r : x_r);
  assign mul_b = trig[31:0];
  assign prod  = $signed({1'b0, ecc_r}) * mul_b;

  assign es_full  = (prod_r + 64'sd4294967296) >>> 33;
  assign ec_full  = (prod_r + 64'sd1073741824) >>> 31;
  assign ec       = ec_full[34:0];
  assign den_full = ONE_Q30 - ec;
  assign num      = 35'(e_r) - 35'(es_r) - 35'(m_r);
  assign absn     = num[34] ? 34'(-num) : num[33:0];

  assign trial = {rem_r, qd_r[33]};
  assign qbit  = trial >= {1'b0, den_r};

  assign diff  = num_r[34] ? 37'(e_r) + 37'($signed({1'b0, qd_r}))
                           : 37'(e_r) - 37'($signed({1'b0, qd_r}));
  always_comb begin
    if (ovf_r) e_new = num_r[34] ? 32'sh7fffffff : 32'sh80000000;
    else if (diff > 37'sd2147483647) e_new = 32'sh7fffffff;
    else if (diff < -37'sd2147483648) e_new = 32'sh80000000;
    else e_new = diff[31:0];
  end

  assign early        = !ovf_r && (qd_r < {18'b0, tolerance});
  assign sts.early    = early;
  assign sts.den_zero = (den_r == 32'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r   <= mean_anomaly;
      e_r   <= mean_anomaly;
      ecc_r <= eccentricity;
    end
    if (cmd.red0 || cmd.red1) a_r <= a_fold;
    if (cmd.red2) begin
      if (a_r > HALF_PI_Q30) begin
        a_r <= a_r - PI_Q30;
        neg_r <= 1'b1;
      end else if (a_r < -HALF_PI_Q30) begin
        a_r <= a_r + PI_Q30;
        neg_r <= 1'b1;
      end else begin
        neg_r <= 1'b0;
      end
      x_r <= GAIN_INV;
      y_r <= '0;
    end
    if (cmd.cordic) begin
      if (!a_r[35]) begin
        x_r <= x_r - sh_y;
        y_r <= y_r + sh_x;
        a_r <= a_r - atan_q30(cmd.cidx);
      end else begin
        x_r <= x_r + sh_y;
        y_r <= y_r - sh_x;
        a_r <= a_r + atan_q30(cmd.cidx);
      end
    end
    if (cmd.mul_s || cmd.mul_c) prod_r <= prod;
    if (cmd.mul_c) es_r <= es_full[31:0];
    if (cmd.prep) begin
      num_r <= num;
      den_r <= (den_full < 35'sd1) ? 32'd1 : den_full[31:0];
      ovf_r <= ({4'b0, absn[33:4]} >= {2'b0, ((den_full < 35'sd1) ? 32'd1 : den_full[31:0])});
      rem_r <= {2'b0, absn[33:4]};
      qd_r  <= {absn[3:0], 30'b0};
    end
    if (cmd.div) begin
      rem_r <= qbit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      qd_r  <= {qd_r[32:0], qbit};
    end
    if (cmd.update) e_r <= e_new;
    if (cmd.out_load) out_r <= e_r;
  end

  assign e_solved = out_r;

endmodule

/* rtl/kes_ctrl.sv */
// Controller of the Kepler solver: sequences folding, CORDIC, multiply, divide and update.
module kes_ctrl
  import kes_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  logic [5:0] max_iterations,
  input  kes_sts_t sts,
  output kes_cmd_t cmd
);

  kes_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] it_r, it_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    it_nxt    = it_r;
    cmd       = '0;
    cmd.cidx  = cnt_r[4:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          it_nxt    = '0;
          state_nxt = (max_iterations == 6'd0) ? ST_FIN : ST_RED0;
        end
      end
      ST_RED0: begin
        cmd.red0  = 1'b1;
        state_nxt = ST_RED1;
      end
      ST_RED1: begin
        cmd.red1  = 1'b1;
        state_nxt = ST_RED2;
      end
      ST_RED2: begin
        cmd.red2  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.cordic = 1'b1;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL_S;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_MUL_S: begin
        cmd.mul_s = 1'b1;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        it_nxt     = it_r + 6'd1;
        state_nxt  = (sts.early || (it_r + 6'd1 == max_iterations)) ? ST_FIN : ST_RED0;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_tvalid    = out_valid_r;
  assign in_tready     = (state_r == ST_IDLE);

  a_cordic_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC) |-> (cnt_r < 6'(CORDIC_STEPS)))
    else $error("CORDIC step count out of range");
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RED0 || state_r == ST_FIN))
    else $error("accepted transaction did not start a solve");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> (it_r < max_iterations))
    else $error("iteration count beyond limit");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !sts.den_zero)
    else $error("zero divisor in division");

endmodule

/* rtl/kepler_eccentric_anomaly_solver.sv */
// Top level of the Kepler equation solver: stream ports, APB registers, controller and datapath.
// Each Newton step runs angle folding (RED0, RED1, RED2), the one-step-per-cycle CORDIC, the sine
// and cosine products on the shared multiplier, numerator and denominator, the restoring divider
// and the update. A solve of N steps ends in out_tvalid (with no step when max_iterations is
// zero); one item is in work at a time, so a new transaction is accepted only when the controller
// is idle again, after the previous result has been loaded into the output register.
// Synchronous active-low reset idles the controller, empties the output register and loads
// max_iterations = 40 and tolerance = 1.
module kepler_eccentric_anomaly_solver
  import kes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] mean_anomaly, [62:32] eccentricity, [63] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] solved E
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [5:0]  max_iter_r;
  logic [15:0] tol_r;
  logic        cfg_wr;
  kes_cmd_t    cmd;
  kes_sts_t    sts;

  // Registers lie at byte addresses 0 and 4; the word index is address bit 2.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= 6'd40;
      tol_r      <= 16'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MAX_ITER: max_iter_r <= cfg_pwdata[5:0];
        REG_TOL:      tol_r      <= cfg_pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAX_ITER: cfg_prdata = {26'b0, max_iter_r};
      REG_TOL:      cfg_prdata = {16'b0, tol_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // The controller only issues commands; all arithmetic lives in the datapath.
  kes_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .max_iterations (max_iter_r),
    .sts            (sts),
    .cmd            (cmd)
  );

  kes_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .mean_anomaly (in_tdata[31:0]),
    .eccentricity (in_tdata[62:32]),
    .tolerance    (tol_r),
    .e_solved     (out_tdata)
  );

endmodule

/* tb/kes_checker.sv */
// Checker for the Kepler solver: watches both streams and the register port, predicts E and compares.
module kes_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI30      = 64'sd3373259426;
  localparam longint HALFPI30  = 64'sd1686629713;
  localparam longint TWOPI30   = 64'sd6746518852;
  localparam longint GAIN30    = 64'sd652032874;
  localparam longint ONE30     = 64'sd1073741824;
  localparam logic [2:0] ADDR_MAX_ITER = 3'd0;
  localparam logic [2:0] ADDR_TOL      = 3'd4;

  logic [5:0]  iter_limit;
  logic [15:0] step_tol;
  logic [31:0] anomaly_q[$];

  longint arctan[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1};

  assign pending_count = anomaly_q.size();

  // >>> on longint is arithmetic, which is the floor shift we need.
  function automatic void rotate_sin_cos(input longint ang28, output longint s,
                                         output longint c);
    longint a, x, y, nx;
    bit flip;
    a = ang28 * 4;
    flip = 0;
    repeat (2) begin
      if (a > PI30) a -= TWOPI30;
      if (a < -PI30) a += TWOPI30;
    end
    if (a > HALFPI30) begin
      a -= PI30;
      flip = 1;
    end else if (a < -HALFPI30) begin
      a += PI30;
      flip = 1;
    end
    x = GAIN30;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= arctan[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += arctan[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic [31:0] solve_kepler(input logic [31:0] m_bits,
                                               input logic [30:0] e_bits);
    longint m, ecc, ea, s, c, es, ec, num, den, stp, mag;
    m = longint'(signed'(m_bits));
    ecc = longint'({33'd0, e_bits});
    ea = m;
    for (int it = 0; it < iter_limit; it++) begin
      rotate_sin_cos(ea, s, c);
      es = (ecc * s + (64'sd1 <<< 32)) >>> 33;
      ec = (ecc * c + (64'sd1 <<< 30)) >>> 31;
      num = ea - es - m;
      den = ONE30 - ec;
      if (den < 1) den = 1;
      stp = (num * ONE30) / den;
      ea = ea - stp;
      if (ea > 64'sd2147483647) ea = 64'sd2147483647;
      if (ea < -64'sd2147483648) ea = -64'sd2147483648;
      mag = stp < 0 ? -stp : stp;
      if (mag < longint'(step_tol)) break;
    end
    return ea[31:0];
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      iter_limit <= 6'd40;
      step_tol <= 16'd1;
      anomaly_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == ADDR_MAX_ITER[2]) iter_limit <= cfg_pwdata[5:0];
        else if (cfg_paddr[2] == ADDR_TOL[2]) step_tol <= cfg_pwdata[15:0];
      end
      if (in_tvalid && in_tready)
        anomaly_q.push_back(solve_kepler(in_tdata[31:0], in_tdata[62:32]));
      if (out_tvalid && out_tready) begin
        if (anomaly_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction: E=%h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = anomaly_q.pop_front();
          if (want !== out_tdata) begin
            if (fail_count < 10)
              $display("E mismatch: expected %h, got %h", want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/kepler_eccentric_anomaly_solver_test.sv */
// Stimulus and verdict for the Kepler solver, with the checker beside the block.
module kepler_eccentric_anomaly_solver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kes_pkg::*;

  localparam logic [2:0] ADDR_MAX_ITER = 3'd0;
  localparam logic [2:0] ADDR_TOL      = 3'd4;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready, cfg_pready;
  logic [63:0] in_tdata;
  logic [31:0] out_tdata, cfg_pwdata, cfg_prdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  int          fail_count, pending_count;
  int          send_idle_pct, recv_stall_pct;

  kepler_eccentric_anomaly_solver i_dut (.*);
  kes_checker i_checker (.*);

  // Free-running 12 ns clock.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The receiver stalls at random; the percentage changes per phase.
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Writes one register through a setup and an access phase, then idles the bus.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one transaction and holds it until the block takes it. Valid stays
  // high afterwards; the next idle cycle, the next item or drain replaces it.
  task automatic send_item(input logic [31:0] m, input logic [30:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, e, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Each solve gives a result, so an empty queue means the block is idle;
  // the task then idles on for a margin that covers the output handshake.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random content weighted toward edges of the fields and near-circular
  // or near-parabolic orbits.
  task automatic send_random;
    logic [31:0] m;
    logic [30:0] e;
    m = $urandom;
    e = 31'($urandom);
    case ($urandom_range(5))
      0: e = 31'(31'h7FFFFFFF - $urandom_range(1 << 20));
      1: e = 31'($urandom_range(255));
      2: m = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: ;
    endcase
    send_item(m, e);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset settings: field extremes, zero and full
    // eccentricity, and the near-one case where the denominator is clamped.
    send_item(32'h00000000, 31'h0);
    send_item(32'h7FFFFFFF, 31'h0);
    send_item(32'h80000000, 31'h7FFFFFFF);
    send_item(32'h7FFFFFFF, 31'h7FFFFFFF);
    send_item(32'h10000000, 31'h7FFFFFFF);
    send_item(32'hF0000000, 31'h40000000);
    send_item(32'h3243F6A8, 31'h55555555);
    send_item(32'h00000001, 31'h7FFFFFFE);
    send_item(32'hFFFFFFFF, 31'h00000001);
    drain();

    // Zero iteration count passes M through; a zero tolerance forces all steps.
    write_reg(ADDR_MAX_ITER, 32'd0);
    write_reg(ADDR_TOL, 32'd0);
    send_item(32'h12345678, 31'h2AAAAAAA);
    send_item(32'h80000000, 31'h7FFFFFFF);
    drain();
    write_reg(ADDR_MAX_ITER, 32'd1);
    send_item(32'h20000000, 31'h60000000);
    send_item(32'hC0000000, 31'h7FFFFFFF);
    drain();
    write_reg(ADDR_TOL, 32'd65535);
    write_reg(ADDR_MAX_ITER, 32'd63);
    send_item(32'h20000000, 31'h60000000);
    send_item(32'h7FFFFFFF, 31'h7FFFFFFF);
    drain();
    // Bits above each register's width are dropped on a write.
    write_reg(3'd0, 32'hFFFFFFC4);
    write_reg(3'd4, 32'h00000003);
    send_item(32'hA0000000, 31'h1FFFFFFF);
    drain();

    // Random phases: both sides busy, lazy sender, slow receiver, and both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 71 : (ph == 3) ? 18 : 0;
      recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 18 : 0;
      write_reg(ADDR_MAX_ITER, (ph == 0) ? 32'd63 : $urandom_range(1, 12));
      write_reg(ADDR_TOL, (ph == 1) ? 32'd0 : $urandom_range(65535));
      for (int n = 0; n < 48; n++) begin
        send_random();
        // Once per phase the sender holds off until the block has emptied.
        if (n == 20) drain();
      end
      drain();
    end

    repeat (80) @(negedge clk);
    if (fail_count == 0)
      $display("kepler_eccentric_anomaly_solver verification clean");
    else
      $display("kepler_eccentric_anomaly_solver verification failed");
    $finish;
  end

  // Worst case is 208 solves of up to 63 steps each, plus stalls.
  initial begin
    #60ms;
    $display("kepler_eccentric_anomaly_solver verification failed");
    $finish;
  end
endmodule
